// ===== rtl/vrt_pkg.sv =====
// vrt_pkg: shared types and fixed constants of the voxel ray traversal block
// no dependencies; used by every module under rtl
package vrt_pkg;

	localparam int XY_BITS      = 6;
	localparam int Z_BITS       = 7;
	localparam int HEIGHT       = 128;
	localparam int ID_BITS      = 8;
	localparam int FRAC_BITS    = 16;
	localparam int ADDR_BITS    = 2 * XY_BITS + Z_BITS;
	localparam int POS_BITS     = 12;
	localparam int CFG_IDX_BITS = 2;

	// divider and square root widths
	localparam int DIV_N_BITS = 33;
	localparam int DIV_D_BITS = 16;
	localparam int SQ_IN_BITS = 48;
	localparam int SQ_OUT_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VALID_ID  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_BLOCK_ID = 2'd1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         vox_x;
		logic [5:0]         vox_y;
		logic [6:0]         vox_z;
		logic [7:0]         block_id;
		logic [21:0]        origin_x;
		logic [21:0]        origin_y;
		logic [22:0]        origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [23:0]        max_dist;
	} vrt_item_t;

	typedef struct packed {
		logic              hit;
		logic [7:0]        hit_id;
		logic [5:0]        hit_x;
		logic [5:0]        hit_y;
		logic signed [7:0] hit_z;
		logic [2:0]        hit_face;
	} vrt_result_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [ID_BITS-1:0]   wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} vrt_mem_req_t;

endpackage

// ===== rtl/vrt_store.sv =====
// vrt_store: voxel id memory, one write and one registered read port
// clears itself after reset, one entry per cycle; uses vrt_pkg
module vrt_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vrt_pkg::vrt_mem_req_t        req,
	output logic [vrt_pkg::ID_BITS-1:0]  rd_data,
	output logic                         clr_busy
);
	import vrt_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [ID_BITS-1:0]   mem [DEPTH];
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// ===== rtl/vrt_div.sv =====
// vrt_div: restoring divider, one quotient bit per cycle
// divisor must be nonzero; uses vrt_pkg
module vrt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [vrt_pkg::DIV_N_BITS-1:0]  dividend,
	input  logic [vrt_pkg::DIV_D_BITS-1:0]  divisor,
	output logic                            done,
	output logic [vrt_pkg::DIV_N_BITS-1:0]  quotient
);
	import vrt_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_N_BITS + 1);

	logic [DIV_N_BITS-1:0] quo_q;
	logic [DIV_D_BITS-1:0] rem_q;
	logic [DIV_D_BITS-1:0] den_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_D_BITS:0]   shifted;
	logic                  ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_N_BITS-1]};
		ge      = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
				cnt_q  <= CNT_BITS'(DIV_N_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? DIV_D_BITS'(shifted - {1'b0, den_q}) : shifted[DIV_D_BITS-1:0];
				quo_q <= {quo_q[DIV_N_BITS-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/vrt_sqrt.sv =====
// vrt_sqrt: integer square root, one result bit per cycle
// uses vrt_pkg
module vrt_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [vrt_pkg::SQ_IN_BITS-1:0]   radicand,
	output logic                             done,
	output logic [vrt_pkg::SQ_OUT_BITS-1:0]  root
);
	import vrt_pkg::*;

	logic [SQ_IN_BITS-1:0] v_q;
	logic [SQ_IN_BITS-1:0] r_q;
	logic [SQ_IN_BITS-1:0] bit_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SQ_IN_BITS-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q    <= radicand;
				r_q    <= '0;
				bit_q  <= SQ_IN_BITS'(1) << (SQ_IN_BITS - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[SQ_OUT_BITS-1:0];

endmodule

// ===== rtl/voxel_ray_traversal_top.sv =====
// voxel ray traversal: a write goes straight to the voxel memory; a cast sums the squared direction,
// takes its square root, runs a setup step and two divisions per moving axis, then repeats
// traversal steps, each a voxel memory read then a test
// one item at a time; a new item is taken while a finished result waits in the output register
// reset: async, active low; voxel memory then clears all 524288 entries, no item taken meanwhile
// configuration writes are taken in every cycle
module voxel_ray_traversal_top #(
	parameter int MAX_STEPS = 100
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  vrt_pkg::vrt_item_t                   item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output vrt_pkg::vrt_result_t                 result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vrt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [7:0]                           cfg_data
);
	import vrt_pkg::*;

	localparam int IW = $clog2(MAX_STEPS + 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_SQRT  = 4'd3;
	localparam logic [3:0] ST_AXIS  = 4'd4;
	localparam logic [3:0] ST_DIV1  = 4'd5;
	localparam logic [3:0] ST_DIV2  = 4'd6;
	localparam logic [3:0] ST_STEP  = 4'd7;
	localparam logic [3:0] ST_PROBE = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	localparam logic signed [POS_BITS-1:0] XY_LIM = POS_BITS'(1 << XY_BITS);
	localparam logic signed [POS_BITS-1:0] Z_LIM  = POS_BITS'(HEIGHT);
	localparam logic [FRAC_BITS:0]         ONE    = (FRAC_BITS+1)'(1 << FRAC_BITS);

	logic [3:0]        state_q;
	vrt_item_t         item_q;
	logic [7:0]        max_valid_q;
	logic [7:0]        base_id_q;

	// cast setup
	logic [1:0]        ax_q;
	logic [31:0]       acc_q;
	logic [40:0]       prod_q;
	logic [SQ_OUT_BITS-1:0] len_q;

	// traversal state
	logic signed [POS_BITS-1:0] pos_q [3];
	logic [2:0]        act_q;
	logic [2:0]        neg_q;
	logic [31:0]       step_q [3];
	logic [31:0]       nb_q [3];
	logic [31:0]       travel_q;
	logic [IW-1:0]     iter_q;
	logic [1:0]        best_q;
	logic              base_q;
	logic              inside_q;

	vrt_result_t       res_q;
	vrt_result_t       result_q;
	logic              result_valid_q;

	// handshakes
	logic item_acc;
	logic clr_busy;
	assign item_ready = (state_q == ST_IDLE) && !clr_busy;
	assign item_acc   = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	// per-axis views of the latched item
	logic [15:0]      mag [3];
	logic [22:0]      org [3];
	logic [15:0]      mag_sel;
	logic [22:0]      org_sel;
	logic             neg_sel;
	logic [FRAC_BITS:0] f_sel;

	always_comb begin
		mag[0] = item_q.dir_x[15] ? 16'(-item_q.dir_x) : 16'(item_q.dir_x);
		mag[1] = item_q.dir_y[15] ? 16'(-item_q.dir_y) : 16'(item_q.dir_y);
		mag[2] = item_q.dir_z[15] ? 16'(-item_q.dir_z) : 16'(item_q.dir_z);
		org[0] = {1'b0, item_q.origin_x};
		org[1] = {1'b0, item_q.origin_y};
		org[2] = item_q.origin_z;
		unique case (ax_q)
			2'd0: begin
				mag_sel = mag[0];
				org_sel = org[0];
				neg_sel = item_q.dir_x[15];
			end
			2'd1: begin
				mag_sel = mag[1];
				org_sel = org[1];
				neg_sel = item_q.dir_y[15];
			end
			default: begin
				mag_sel = mag[2];
				org_sel = org[2];
				neg_sel = item_q.dir_z[15];
			end
		endcase
		// distance to the first boundary, in fractions of a cell
		f_sel = neg_sel ? {1'b0, org_sel[FRAC_BITS-1:0]}
		                : ONE - {1'b0, org_sel[FRAC_BITS-1:0]};
	end

	// one shared multiplier: squares during setup, first-boundary numerator per axis
	logic [16:0] mul_a;
	logic [23:0] mul_b;
	logic [40:0] prod;
	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a = {1'b0, mag_sel};
			mul_b = {8'd0, mag_sel};
		end else begin
			mul_a = f_sel;
			mul_b = len_q;
		end
		prod = 41'(mul_a) * 41'(mul_b);
	end

	// square root and divider
	logic                    sq_start;
	logic                    sq_done;
	logic [SQ_OUT_BITS-1:0]  sq_root;
	logic                    div_start;
	logic [DIV_N_BITS-1:0]   div_num;
	logic                    div_done;
	logic [DIV_N_BITS-1:0]   div_q;
	logic [31:0]             div_sat;

	assign sq_start  = (state_q == ST_CHK) && (acc_q >= 32'd3);
	assign div_start = ((state_q == ST_AXIS) && (mag_sel != '0))
	                || ((state_q == ST_DIV1) && div_done);
	// dividing by |d| << 8 is done as dividing the numerator >> 8 by |d|
	assign div_num   = (state_q == ST_AXIS) ? {1'b0, len_q, 8'd0} : prod_q[40:8];
	assign div_sat   = div_q[DIV_N_BITS-1] ? 32'hFFFF_FFFF : div_q[31:0];

	vrt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({acc_q, 16'd0}),
		.done     (sq_done),
		.root     (sq_root)
	);

	vrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (mag_sel),
		.done     (div_done),
		.quotient (div_q)
	);

	// traversal step: nearest boundary axis, ties to the lower axis
	logic                        found;
	logic [1:0]                  best;
	logic signed [POS_BITS-1:0]  npos [3];
	logic                        base_c;
	logic                        inside_c;
	always_comb begin
		found = 1'b0;
		best  = 2'd0;
		for (int a = 0; a < 3; a++) begin
			if (act_q[a] && (!found || nb_q[a] < nb_q[best])) begin
				found = 1'b1;
				best  = 2'(a);
			end
		end
		for (int a = 0; a < 3; a++) begin
			npos[a] = pos_q[a];
		end
		npos[best] = pos_q[best] + (neg_q[best] ? -POS_BITS'(1) : POS_BITS'(1));
		base_c   = npos[2] < 0;
		inside_c = !base_c && (npos[2] < Z_LIM)
		        && (npos[0] >= 0) && (npos[0] < XY_LIM)
		        && (npos[1] >= 0) && (npos[1] < XY_LIM);
	end

	// voxel memory access
	vrt_mem_req_t          mreq;
	logic [ID_BITS-1:0]    rd_data;
	always_comb begin
		mreq.we    = item_acc && (item.opcode == OP_WRITE) && ({1'b0, item.vox_z} < 8'(HEIGHT));
		mreq.waddr = {item.vox_z[Z_BITS-1:0], item.vox_y[XY_BITS-1:0], item.vox_x[XY_BITS-1:0]};
		mreq.wdata = item.block_id[ID_BITS-1:0];
		mreq.re    = (state_q == ST_STEP) && found && inside_c;
		mreq.raddr = {npos[2][Z_BITS-1:0], npos[1][XY_BITS-1:0], npos[0][XY_BITS-1:0]};
	end

	vrt_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	// probe result and distance bookkeeping
	logic        solid;
	logic [32:0] tsum;
	logic [31:0] tsat;
	logic [31:0] delta;
	always_comb begin
		solid = base_q || (inside_q && (rd_data != '0) && (8'(rd_data) <= max_valid_q));
		delta = nb_q[best_q];
		tsum  = {1'b0, travel_q} + {1'b0, delta};
		tsat  = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
	end

	// output register frees the sequencer while the result waits
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
			result_q       <= res_q;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_valid_q <= 8'd255;
			base_id_q   <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_VALID_ID) begin
				max_valid_q <= cfg_data;
			end else if (cfg_index == REG_BASE_BLOCK_ID) begin
				base_id_q <= cfg_data;
			end
		end
	end

	// cast sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			item_q   <= '0;
			ax_q     <= '0;
			acc_q    <= '0;
			prod_q   <= '0;
			len_q    <= '0;
			act_q    <= '0;
			neg_q    <= '0;
			travel_q <= '0;
			iter_q   <= '0;
			best_q   <= '0;
			base_q   <= 1'b0;
			inside_q <= 1'b0;
			res_q    <= '0;
			for (int a = 0; a < 3; a++) begin
				pos_q[a]  <= '0;
				step_q[a] <= '0;
				nb_q[a]   <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.opcode == OP_CAST)) begin
						item_q  <= item;
						ax_q    <= '0;
						acc_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				// squares one axis a cycle, each square registered and added to the sum in the next cycle
				ST_SQ: begin
					prod_q <= prod;
					if (ax_q != 2'd0) begin
						acc_q <= acc_q + prod_q[31:0];
					end
					if (ax_q == 2'd3) begin
						state_q <= ST_CHK;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				ST_CHK: begin
					ax_q <= '0;
					if (acc_q < 32'd3) begin
						// direction too short
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						len_q   <= sq_root;
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					pos_q[ax_q] <= POS_BITS'(org_sel[22:FRAC_BITS]);
					act_q[ax_q] <= mag_sel != '0;
					neg_q[ax_q] <= neg_sel;
					prod_q      <= prod;
					if (mag_sel == '0) begin
						step_q[ax_q] <= '0;
						nb_q[ax_q]   <= '0;
						if (ax_q == 2'd2) begin
							travel_q <= '0;
							iter_q   <= '0;
							state_q  <= ST_STEP;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						step_q[ax_q] <= div_sat;
						state_q      <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						nb_q[ax_q] <= div_sat;
						if (ax_q == 2'd2) begin
							travel_q <= '0;
							iter_q   <= '0;
							state_q  <= ST_STEP;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_AXIS;
						end
					end
				end
				// move one cell and read the voxel memory, or end at the step limit or with no moving axis
				ST_STEP: begin
					if ((iter_q == IW'(MAX_STEPS)) || !found) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						for (int a = 0; a < 3; a++) begin
							pos_q[a] <= npos[a];
						end
						best_q   <= best;
						base_q   <= base_c;
						inside_q <= inside_c;
						state_q  <= ST_PROBE;
					end
				end
				// test the cell, end on a hit or past the maximum distance, else advance the boundaries
				ST_PROBE: begin
					if (solid) begin
						res_q.hit      <= 1'b1;
						res_q.hit_id   <= base_q ? base_id_q : 8'(rd_data);
						res_q.hit_x    <= pos_q[0][5:0];
						res_q.hit_y    <= pos_q[1][5:0];
						res_q.hit_z    <= pos_q[2][7:0];
						res_q.hit_face <= {best_q, neg_q[best_q]};
						state_q        <= ST_OUT;
					end else if (tsat > {8'd0, item_q.max_dist}) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						travel_q <= tsat;
						iter_q   <= iter_q + 1'b1;
						// stepping axis reloads its step length, the others move closer
						for (int a = 0; a < 3; a++) begin
							if (act_q[a]) begin
								nb_q[a] <= (2'(a) == best_q) ? step_q[a] : nb_q[a] - delta;
							end
						end
						state_q <= ST_STEP;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks on the sequencer
	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !item_ready)
		else $error("item taken during memory clear");

	a_cast_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && (item.opcode == OP_CAST)) |=> (state_q == ST_SQ))
		else $error("cast transaction did not start setup");

	a_probe_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> ($past(state_q) == ST_STEP))
		else $error("probe without a step");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (iter_q < IW'(MAX_STEPS)))
		else $error("step count beyond limit");

endmodule

// ===== verif/traversal_scoreboard.sv =====
`timescale 1ns / 100ps
// traversal_scoreboard: mirror of the voxel store and registers, cast prediction, result checks
// depends on vrt_pkg for the item and result types, register indices and opcodes

class traversal_scoreboard;
	bit [7:0] vox_mem [0:524287];
	bit [7:0] max_valid_id = 8'd255;
	bit [7:0] base_id = 8'd1;
	int unsigned trace_steps = 100;
	vrt_pkg::vrt_result_t pending_q[$];
	int errors, casts, hits, writes;

	function void set_register(logic [1:0] idx, logic [7:0] val);
		if (idx == vrt_pkg::REG_MAX_VALID_ID) max_valid_id = val;
		else if (idx == vrt_pkg::REG_BASE_BLOCK_ID) base_id = val;
	endfunction

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function longint unsigned clip32(longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	// base below z = 0 is solid, outside the volume is empty
	function bit solid_at(int x, int y, int z, output bit [7:0] id);
		bit [7:0] v;
		id = 0;
		if (z < 0) begin
			id = base_id;
			return 1;
		end
		if (z >= 128 || x < 0 || y < 0 || x >= 64 || y >= 64) return 0;
		v = vox_mem[(z * 64 + y) * 64 + x];
		if (v == 0 || v > max_valid_id) return 0;
		id = v;
		return 1;
	endfunction

	function void note_item(vrt_pkg::vrt_item_t it);
		longint unsigned org[3], stride[3], bnd[3];
		longint unsigned s, len, mag, den, f, travelled, delta;
		int dv[3], cpos[3], sgn[3];
		int best;
		bit [7:0] id;
		vrt_pkg::vrt_result_t r;
		if (it.opcode == vrt_pkg::OP_WRITE) begin
			vox_mem[{it.vox_z, it.vox_y, it.vox_x}] = it.block_id;
			writes++;
			return;
		end
		casts++;
		r = '0;
		org[0] = it.origin_x;
		org[1] = it.origin_y;
		org[2] = it.origin_z;
		dv[0] = $signed(it.dir_x);
		dv[1] = $signed(it.dir_y);
		dv[2] = $signed(it.dir_z);
		s = 0;
		for (int a = 0; a < 3; a++) begin
			mag = longint'(dv[a] < 0 ? -dv[a] : dv[a]);
			s += mag * mag;
		end
		// too short a direction ends in a miss
		if (s < 3) begin
			pending_q.insert(pending_q.size(), r);
			return;
		end
		len = int_sqrt(s << 16);
		for (int a = 0; a < 3; a++) begin
			mag = longint'(dv[a] < 0 ? -dv[a] : dv[a]);
			cpos[a] = int'(org[a] >> 16);
			if (mag == 0) begin
				sgn[a] = 0;
				stride[a] = 0;
				bnd[a] = 0;
			end else begin
				den = mag << 8;
				f = (dv[a] > 0) ? 65536 - (org[a] & 64'hFFFF) : (org[a] & 64'hFFFF);
				sgn[a] = (dv[a] > 0) ? 1 : -1;
				stride[a] = clip32((len << 16) / den);
				bnd[a] = clip32((f * len) / den);
			end
		end
		travelled = 0;
		for (int n = 0; n < trace_steps; n++) begin
			best = -1;
			for (int a = 0; a < 3; a++)
				if (sgn[a] != 0 && (best < 0 || bnd[a] < bnd[best])) best = a;
			if (best < 0) break;
			cpos[best] += sgn[best];
			if (solid_at(cpos[0], cpos[1], cpos[2], id)) begin
				r.hit = 1;
				r.hit_id = id;
				r.hit_x = cpos[0][5:0];
				r.hit_y = cpos[1][5:0];
				r.hit_z = cpos[2][7:0];
				r.hit_face = 3'(2 * best + (sgn[best] < 0 ? 1 : 0));
				hits++;
				break;
			end
			delta = bnd[best];
			travelled = clip32(travelled + delta);
			if (travelled > it.max_dist) break;
			for (int a = 0; a < 3; a++)
				if (sgn[a] != 0) bnd[a] -= delta;
			bnd[best] = stride[best];
		end
		pending_q.insert(pending_q.size(), r);
	endfunction

	function void check_result(vrt_pkg::vrt_result_t got);
		vrt_pkg::vrt_result_t want;
		if (pending_q.size() == 0) begin
			$error("result with nothing pending: %p", got);
			errors++;
			return;
		end
		want = pending_q.pop_front();
		if (got.hit !== want.hit) begin
			$error("hit expected %0d got %0d", want.hit, got.hit);
			errors++;
		end
		if (got.hit_id !== want.hit_id) begin
			$error("hit_id expected %0d got %0d", want.hit_id, got.hit_id);
			errors++;
		end
		if (got.hit_x !== want.hit_x) begin
			$error("hit_x expected %0d got %0d", want.hit_x, got.hit_x);
			errors++;
		end
		if (got.hit_y !== want.hit_y) begin
			$error("hit_y expected %0d got %0d", want.hit_y, got.hit_y);
			errors++;
		end
		if (got.hit_z !== want.hit_z) begin
			$error("hit_z expected %0d got %0d", want.hit_z, got.hit_z);
			errors++;
		end
		if (got.hit_face !== want.hit_face) begin
			$error("hit_face expected %0d got %0d", want.hit_face, got.hit_face);
			errors++;
		end
	endfunction
endclass

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives writes and casts into voxel_ray_traversal_top and checks every result
// depends on vrt_pkg, voxel_ray_traversal_top and traversal_scoreboard

module testbench;
	import vrt_pkg::*;

	localparam int TRACE_STEPS = 100;
	localparam int SETTLE_CYCLES = 600;   // longer than one full cast
	localparam int PHASE_ITEMS = 435;
	localparam int ITEM_BITS = $bits(vrt_item_t);
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd2;  // not a real register

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	vrt_item_t item;
	logic result_valid;
	logic result_ready;
	vrt_result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [7:0] cfg_data;

	bit quiet;      // no idling on either side
	int ready_hold;

	traversal_scoreboard sb = new;

	voxel_ray_traversal_top #(.MAX_STEPS(TRACE_STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// result side: random stall bursts, none in the quiet part
	always @(posedge clk) begin
		if (quiet) begin
			result_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 15);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// every result transaction is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	// valid is left high after a transaction so back-to-back items go without a gap
	task automatic send_item(vrt_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let all pending casts come back, then let writes settle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random filler for the fields that an item does not use
	function automatic vrt_item_t noise_item();
		logic [191:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return vrt_item_t'(noise[ITEM_BITS-1:0]);
	endfunction

	function automatic vrt_item_t voxel_write(int x, int y, int z, int id);
		vrt_item_t it;
		it = noise_item();
		it.opcode = OP_WRITE;
		it.vox_x = 6'(x);
		it.vox_y = 6'(y);
		it.vox_z = 7'(z);
		it.block_id = 8'(id);
		return it;
	endfunction

	// positions in 1/65536 cell units
	function automatic vrt_item_t ray(int ox, int oy, int oz, int dx, int dy, int dz, int md);
		vrt_item_t it;
		it = noise_item();
		it.opcode = OP_CAST;
		it.origin_x = 22'(ox);
		it.origin_y = 22'(oy);
		it.origin_z = 23'(oz);
		it.dir_x = 16'(dx);
		it.dir_y = 16'(dy);
		it.dir_z = 16'(dz);
		it.max_dist = 24'(md);
		return it;
	endfunction

	// writes mostly fill a small scene near the floor so that casts find something
	function automatic vrt_item_t random_write();
		if ($urandom_range(0, 4) == 0)
			return voxel_write($urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 127), $urandom_range(0, 255));
		return voxel_write($urandom_range(8, 23), $urandom_range(8, 23),
			$urandom_range(0, 15), ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255));
	endfunction

	function automatic int random_dir();
		if ($urandom_range(0, 5) == 0) return 0;
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic vrt_item_t random_cast();
		vrt_item_t it;
		int md;
		md = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40 << 16) : $urandom_range(0, 24'hFFFFFF);
		it = ray(($urandom_range(6, 25) << 16) | $urandom_range(0, 65535),
			($urandom_range(6, 25) << 16) | $urandom_range(0, 65535),
			($urandom_range(0, 20) << 16) | $urandom_range(0, 65535),
			random_dir(), random_dir(), random_dir(), md);
		// some origins anywhere in the volume, touching every origin bit
		if ($urandom_range(0, 7) == 0) begin
			it.origin_x = 22'($urandom);
			it.origin_y = 22'($urandom);
			it.origin_z = 23'($urandom);
		end
		return it;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 35) send_item(random_write());
			else send_item(random_cast());
		end
	endtask

	initial begin
		#120_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_VALID_ID;
		cfg_data = 8'd0;
		quiet = 1'b0;
		sb.trace_steps = TRACE_STEPS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with reset register values
		send_item(ray(10 << 16, 10 << 16, 3 << 16, 0, 0, 0, 24'hFFFFFF));      // zero direction
		send_item(ray(10 << 16, 10 << 16, 3 << 16, 1, 1, 0, 24'hFFFFFF));      // too short
		send_item(ray(10 << 16, 10 << 16, 3 << 16 | 32768, 0, 0, -16384, 24'hFFFFFF)); // into base
		send_item(voxel_write(10, 10, 5, 5));
		send_item(voxel_write(0, 0, 0, 255));
		send_item(voxel_write(63, 63, 127, 1));
		send_item(ray(10 << 16 | 32768, 10 << 16 | 32768, 32768, 0, 0, 16384, 24'hFFFFFF));
		// origin cell itself solid, never tested
		send_item(ray(10 << 16 | 32768, 10 << 16 | 32768, 5 << 16 | 100, 0, 0, 16384, 24'hFFFFFF));
		send_item(ray(5 << 16, 5 << 16, 5 << 16, -16384, -16384, -16384, 24'hFFFFFF));
		send_item(ray(22'h3FFFFF, 22'h3FFFFF, 23'h7FFFFF, 16384, 16384, 16384, 24'hFFFFFF));
		send_item(ray(60 << 16 | 32768, 4 << 16, 9 << 16, 16384, 0, 0, 24'hFFFFFF)); // leaves volume
		send_item(ray(4 << 16, 32768, 9 << 16, 0, -16384, 0, 24'hFFFFFF));
		send_item(ray(10 << 16 | 32768, 10 << 16 | 32768, 32768, 0, 0, 16384, 0));  // no distance
		send_item(ray(62 << 16 | 32768, 62 << 16 | 32768, 126 << 16, 300, 300, 16384, 24'hFFFFFF));
		send_item(ray(1 << 16, 1 << 16, 1 << 16, -16384, -16384, -4000, 24'hFFFFFF));
		send_item(ray(20 << 16, 20 << 16, 20 << 16, 16384, 3, 0, 40 << 16));
		random_phase(PHASE_ITEMS);

		// all pending results back before any register moves
		drain();
		write_reg(REG_MAX_VALID_ID, 8'd1);
		write_reg(REG_BASE_BLOCK_ID, 8'd255);
		send_item(ray(10 << 16 | 32768, 10 << 16 | 32768, 32768, 0, 0, 16384, 24'hFFFFFF));
		random_phase(PHASE_ITEMS);

		drain();
		write_reg(REG_MAX_VALID_ID, 8'd100);
		write_reg(REG_BASE_BLOCK_ID, 8'd7);
		write_reg(REG_SPARE, 8'd3);
		random_phase(PHASE_ITEMS);

		// last part back at the reset register values with no idling anywhere
		drain();
		write_reg(REG_MAX_VALID_ID, 8'd255);
		write_reg(REG_BASE_BLOCK_ID, 8'd1);
		quiet = 1'b1;
		random_phase(PHASE_ITEMS);

		drain();
		$display("covered %0d voxel writes and %0d casts, %0d of them hits",
			sb.writes, sb.casts, sb.hits);
		$display("register settings: reset, low id limit, mid limit with spare index write");
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/vrt_pkg.sv
rtl/vrt_store.sv
rtl/vrt_div.sv
rtl/vrt_sqrt.sv
rtl/voxel_ray_traversal_top.sv
verif/traversal_scoreboard.sv
verif/testbench.sv
